/* src/pcs_pkg.sv */
// pearson correlation similarity: shared types and constants
// item structs for both channels and the multiplier request/response structs
// no dependencies
package pcs_pkg;

   localparam int unsigned SAMPLE_W = 17;
   localparam int unsigned WORD_W   = 64;
   localparam int unsigned PROD_W   = 128;
   localparam int unsigned HALF_W   = 32;
   localparam int unsigned QUOT_W   = 17;
   localparam int unsigned ROOT_LIMIT_BIT = 46;

   localparam logic [SAMPLE_W-1:0] ONE_Q16  = 17'h10000;
   localparam logic [SAMPLE_W-1:0] HALF_Q16 = 17'h08000;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_a;
      logic [SAMPLE_W-1:0] sample_b;
      logic                last_pair;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] similarity;
      logic                flat_input;
      logic                overflow;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] product;
   } mul_rsp_type;

endpackage

/* src/pcs_mul.sv */
// pearson correlation similarity: shared 64 x 64 multiplier
// four 32 x 32 partial products, one per cycle, accumulated into a 128-bit sum
// depends on pcs_pkg
module pcs_mul (
   input  logic                clock,
   input  logic                reset,
   input  pcs_pkg::mul_req_type mul_req,
   output pcs_pkg::mul_rsp_type mul_rsp
);
   import pcs_pkg::*;

   logic                busy_ff;
   logic [2:0]          step_ff;
   logic                pv_ff;
   logic [1:0]          sh_ff;
   logic [WORD_W-1:0]   opx_ff;
   logic [WORD_W-1:0]   opy_ff;
   logic [WORD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   acc_ff;
   logic [HALF_W-1:0]   xh;
   logic [HALF_W-1:0]   yh;
   logic [PROD_W-1:0]   addend;

   always_comb begin
      xh = step_ff[1] ? opx_ff[WORD_W-1:HALF_W] : opx_ff[HALF_W-1:0];
      yh = step_ff[0] ? opy_ff[WORD_W-1:HALF_W] : opy_ff[HALF_W-1:0];
      case (sh_ff)
         2'd0:    addend = {64'd0, prod_ff};
         2'd1:    addend = {32'd0, prod_ff, 32'd0};
         default: addend = {prod_ff, 64'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pv_ff   <= 1'b0;
         step_ff <= '0;
      end else if (mul_req.start) begin
         busy_ff <= 1'b1;
         pv_ff   <= 1'b0;
         step_ff <= '0;
         opx_ff  <= mul_req.x;
         opy_ff  <= mul_req.y;
         acc_ff  <= '0;
      end else if (busy_ff) begin
         if (!step_ff[2]) begin
            prod_ff <= WORD_W'(xh) * WORD_W'(yh);
            sh_ff   <= {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
            pv_ff   <= 1'b1;
            step_ff <= step_ff + 3'd1;
         end else begin
            pv_ff <= 1'b0;
         end
         if (pv_ff) begin
            acc_ff <= acc_ff + addend;
         end
         if (step_ff[2] && !pv_ff) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign mul_rsp.done    = busy_ff && step_ff[2] && !pv_ff;
   assign mul_rsp.product = acc_ff;

endmodule

/* src/pearson_correlation_similarity.sv */
// Pearson correlation similarity of two paired sample streams. Each item is one pair of
// Q1.16 samples; the item flagged last_pair closes the vector and yields one result item,
// (r+1)/2 in Q1.16, after which all sums clear. Every multiply goes through one shared
// 64 x 64 unit built from four 32 x 32 partial products, so a pair that fits in the run
// takes three multiplies from acceptance to the next acceptance, for the squares and the
// cross product. A last pair adds seven more multiplies, a 64-step square root,
// normalizing shifts and a 17-step divide; a zero variance ends after the fourth of
// those multiplies, and an overflowed run skips all of them.
// req_ready is low while a pair is in work; a finished result waits in the output
// register and holds up input only when the previous result is still waiting there.
//
// depends on pcs_pkg, pcs_mul
module pearson_correlation_similarity #(
   parameter int unsigned MAX_SAMPLES = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pcs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pcs_pkg::rsp_type rsp_data
);
   import pcs_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int unsigned SUM_W = SAMPLE_W + CNT_W;
   localparam int unsigned SQ_W  = 2 * SAMPLE_W + CNT_W;

   typedef enum logic [4:0] {
      S_IDLE, S_AA, S_BB, S_AB, S_LAST, S_M1, S_M2, S_M3, S_M4, S_FLAT,
      S_M5, S_M6, S_M7, S_SQRT, S_CLAMP, S_SHIFT, S_DIV, S_FINAL, S_EMIT
   } state_type;

   state_type             state_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [SUM_W-1:0]      sum_a_ff;
   logic [SUM_W-1:0]      sum_b_ff;
   logic [SQ_W-1:0]       sum_sq_a_ff;
   logic [SQ_W-1:0]       sum_sq_b_ff;
   logic [SQ_W-1:0]       sum_cross_ff;
   logic                  overflowed_ff;
   logic [SAMPLE_W-1:0]   a_ff;
   logic [SAMPLE_W-1:0]   b_ff;
   logic                  last_ff;
   logic                  mul_start_ff;
   logic [WORD_W-1:0]     mx_ff;
   logic [WORD_W-1:0]     my_ff;
   logic [WORD_W-1:0]     tmp_ff;
   logic [WORD_W-1:0]     va_ff;
   logic [WORD_W-1:0]     vb_ff;
   logic                  neg_ff;
   logic [WORD_W-1:0]     mag_ff;
   logic [WORD_W-1:0]     d_ff;
   logic [PROD_W-1:0]     p_ff;
   logic [WORD_W:0]       rem_ff;
   logic [WORD_W-1:0]     root_ff;
   logic [5:0]            cnt_ff;
   logic [WORD_W-1:0]     dr_ff;
   logic [WORD_W-1:0]     dv_ff;
   logic [QUOT_W-1:0]     q_ff;
   rsp_type               res_ff;
   rsp_type               rsp_data_ff;
   logic                  rsp_valid_ff;

   mul_req_type           mul_req;
   mul_rsp_type           mul_rsp;
   logic [SAMPLE_W-1:0]   a_clamped;
   logic [SAMPLE_W-1:0]   b_clamped;
   logic [WORD_W-1:0]     prod_lo;
   logic [WORD_W-1:0]     c_diff;
   logic [WORD_W+2:0]     sq_cat;
   logic [WORD_W+2:0]     sq_trial;
   logic                  sq_ge;
   logic                  div_ge;
   logic [QUOT_W-1:0]     t_val;
   logic                  emit_ok;

   assign mul_req.start = mul_start_ff;
   assign mul_req.x     = mx_ff;
   assign mul_req.y     = my_ff;

   pcs_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   always_comb begin
      a_clamped = (req_data.sample_a > ONE_Q16) ? ONE_Q16 : req_data.sample_a;
      b_clamped = (req_data.sample_b > ONE_Q16) ? ONE_Q16 : req_data.sample_b;
      prod_lo   = mul_rsp.product[WORD_W-1:0];
      c_diff    = tmp_ff - prod_lo;
      sq_cat    = {rem_ff, p_ff[PROD_W-1:PROD_W-2]};
      sq_trial  = {1'b0, root_ff, 2'b01};
      sq_ge     = sq_cat >= sq_trial;
      div_ge    = dr_ff >= dv_ff;
      t_val     = (q_ff > HALF_Q16) ? HALF_Q16 : q_ff;
      emit_ok   = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         sum_a_ff      <= '0;
         sum_b_ff      <= '0;
         sum_sq_a_ff   <= '0;
         sum_sq_b_ff   <= '0;
         sum_cross_ff  <= '0;
         overflowed_ff <= 1'b0;
         mul_start_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mul_start_ff <= 1'b0;
         if (state_ff == S_EMIT && emit_ok) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  a_ff    <= a_clamped;
                  b_ff    <= b_clamped;
                  last_ff <= req_data.last_pair;
                  if (count_ff >= CNT_W'(MAX_SAMPLES)) begin
                     overflowed_ff <= 1'b1;
                     state_ff      <= S_LAST;
                  end else begin
                     count_ff     <= count_ff + CNT_W'(1);
                     mx_ff        <= WORD_W'(a_clamped);
                     my_ff        <= WORD_W'(a_clamped);
                     mul_start_ff <= 1'b1;
                     state_ff     <= S_AA;
                  end
               end
            end
            S_AA: begin
               if (mul_rsp.done) begin
                  sum_sq_a_ff  <= sum_sq_a_ff + mul_rsp.product[SQ_W-1:0];
                  mx_ff        <= WORD_W'(b_ff);
                  my_ff        <= WORD_W'(b_ff);
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_BB;
               end
            end
            S_BB: begin
               if (mul_rsp.done) begin
                  sum_sq_b_ff  <= sum_sq_b_ff + mul_rsp.product[SQ_W-1:0];
                  mx_ff        <= WORD_W'(a_ff);
                  my_ff        <= WORD_W'(b_ff);
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_AB;
               end
            end
            S_AB: begin
               if (mul_rsp.done) begin
                  sum_cross_ff <= sum_cross_ff + mul_rsp.product[SQ_W-1:0];
                  sum_a_ff     <= sum_a_ff + SUM_W'(a_ff);
                  sum_b_ff     <= sum_b_ff + SUM_W'(b_ff);
                  state_ff     <= S_LAST;
               end
            end
            S_LAST: begin
               if (!last_ff) begin
                  state_ff <= S_IDLE;
               end else if (overflowed_ff) begin
                  res_ff   <= '{similarity: '0, flat_input: 1'b0, overflow: 1'b1};
                  state_ff <= S_EMIT;
               end else begin
                  mx_ff        <= WORD_W'(count_ff);
                  my_ff        <= WORD_W'(sum_sq_a_ff);
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_M1;
               end
            end
            S_M1: begin
               if (mul_rsp.done) begin
                  tmp_ff       <= prod_lo;
                  mx_ff        <= WORD_W'(sum_a_ff);
                  my_ff        <= WORD_W'(sum_a_ff);
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_M2;
               end
            end
            S_M2: begin
               if (mul_rsp.done) begin
                  va_ff        <= c_diff;
                  mx_ff        <= WORD_W'(count_ff);
                  my_ff        <= WORD_W'(sum_sq_b_ff);
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_M3;
               end
            end
            S_M3: begin
               if (mul_rsp.done) begin
                  tmp_ff       <= prod_lo;
                  mx_ff        <= WORD_W'(sum_b_ff);
                  my_ff        <= WORD_W'(sum_b_ff);
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_M4;
               end
            end
            S_M4: begin
               if (mul_rsp.done) begin
                  vb_ff    <= c_diff;
                  state_ff <= S_FLAT;
               end
            end
            S_FLAT: begin
               if (va_ff == '0 || vb_ff == '0) begin
                  res_ff   <= '{similarity: ONE_Q16, flat_input: 1'b1, overflow: 1'b0};
                  state_ff <= S_EMIT;
               end else begin
                  mx_ff        <= WORD_W'(count_ff);
                  my_ff        <= WORD_W'(sum_cross_ff);
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_M5;
               end
            end
            S_M5: begin
               if (mul_rsp.done) begin
                  tmp_ff       <= prod_lo;
                  mx_ff        <= WORD_W'(sum_a_ff);
                  my_ff        <= WORD_W'(sum_b_ff);
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_M6;
               end
            end
            S_M6: begin
               if (mul_rsp.done) begin
                  neg_ff       <= c_diff[WORD_W-1];
                  mag_ff       <= c_diff[WORD_W-1] ? (WORD_W'(0) - c_diff) : c_diff;
                  mx_ff        <= va_ff;
                  my_ff        <= vb_ff;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_M7;
               end
            end
            S_M7: begin
               if (mul_rsp.done) begin
                  p_ff     <= mul_rsp.product;
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_SQRT;
               end
            end
            S_SQRT: begin
               p_ff    <= {p_ff[PROD_W-3:0], 2'b00};
               rem_ff  <= sq_ge ? (WORD_W+1)'(sq_cat - sq_trial) : sq_cat[WORD_W:0];
               root_ff <= {root_ff[WORD_W-2:0], sq_ge};
               cnt_ff  <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  state_ff <= S_CLAMP;
               end
            end
            S_CLAMP: begin
               d_ff     <= root_ff;
               mag_ff   <= (mag_ff > root_ff) ? root_ff : mag_ff;
               state_ff <= S_SHIFT;
            end
            S_SHIFT: begin
               if (d_ff[WORD_W-1:ROOT_LIMIT_BIT] != '0) begin
                  d_ff   <= d_ff >> 1;
                  mag_ff <= mag_ff >> 1;
               end else begin
                  dr_ff    <= {mag_ff[WORD_W-17:0], 16'd0} + d_ff;
                  dv_ff    <= {d_ff[WORD_W-18:0], 17'd0};
                  q_ff     <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_ge) begin
                  dr_ff <= dr_ff - dv_ff;
               end
               dv_ff  <= dv_ff >> 1;
               q_ff   <= {q_ff[QUOT_W-2:0], div_ge};
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'(QUOT_W - 1)) begin
                  state_ff <= S_FINAL;
               end
            end
            S_FINAL: begin
               res_ff.similarity <= neg_ff ? (HALF_Q16 - t_val) : (HALF_Q16 + t_val);
               res_ff.flat_input <= 1'b0;
               res_ff.overflow   <= 1'b0;
               state_ff          <= S_EMIT;
            end
            S_EMIT: begin
               if (emit_ok) begin
                  rsp_data_ff   <= res_ff;
                  count_ff      <= '0;
                  sum_a_ff      <= '0;
                  sum_b_ff      <= '0;
                  sum_sq_a_ff   <= '0;
                  sum_sq_b_ff   <= '0;
                  sum_cross_ff  <= '0;
                  overflowed_ff <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/pcs_checker.sv */
// pearson correlation similarity: port-level checker and its bind
// watches both channels of the top level
// depends on pcs_pkg, pearson_correlation_similarity
module pcs_assert (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pcs_pkg::rsp_type rsp_data
);
   import pcs_pkg::*;

   // result item holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // one item in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after an accepted item");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.flat_input && rsp_data.overflow))
      else $error("flat and overflow both set");

   a_flag_values: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.overflow || rsp_data.similarity == '0) &&
                    (!rsp_data.flat_input || rsp_data.similarity == ONE_Q16))
      else $error("flagged result with wrong similarity");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.similarity <= ONE_Q16)
      else $error("similarity above one");

endmodule

bind pearson_correlation_similarity pcs_assert u_pcs_assert (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* tb/sv/pcs_checker.sv */
// pearson correlation similarity: predictor and result checker
// watches both channels, predicts one result item per closed vector, compares in order
// depends on pcs_pkg
`timescale 1ns / 1ps

module pcs_checker #(
   parameter int unsigned MAX_SAMPLES = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  pcs_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  pcs_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               results_owed
);
   import pcs_pkg::*;

   rsp_type     expected_rsps[$];
   int unsigned run_length;
   logic [63:0] acc_a, acc_b, acc_sq_a, acc_sq_b, acc_cross;
   bit          run_overflowed;

   initial begin
      fail_count   = 0;
      results_owed = 0;
   end

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic logic [63:0] clamp_q16(input logic [SAMPLE_W-1:0] v);
      return (v > ONE_Q16) ? 64'(ONE_Q16) : 64'(v);
   endfunction

   function automatic logic [63:0] isqrt_product(input logic [63:0] x, input logic [63:0] y);
      logic [127:0] prod;
      logic [63:0]  root;
      logic [63:0]  cand;
      prod = {64'd0, x} * {64'd0, y};
      root = 0;
      for (int bit_i = 61; bit_i >= 0; bit_i--) begin
         cand = root | (64'd1 << bit_i);
         if ({64'd0, cand} * {64'd0, cand} <= prod) root = cand;
      end
      return root;
   endfunction

   function automatic rsp_type correlation_result();
      rsp_type     r;
      logic [63:0] n, va, vb, c, mag, d, t;
      bit          neg;
      r = '0;
      if (run_overflowed) begin
         r.overflow = 1'b1;
         return r;
      end
      n  = 64'(run_length);
      va = n * acc_sq_a - acc_a * acc_a;
      vb = n * acc_sq_b - acc_b * acc_b;
      if (va == 0 || vb == 0) begin
         r.flat_input = 1'b1;
         r.similarity = ONE_Q16;
         return r;
      end
      c   = n * acc_cross - acc_a * acc_b;
      neg = c[63];
      mag = neg ? (64'd0 - c) : c;
      d   = isqrt_product(va, vb);
      if (mag > d) mag = d;
      while (d >= (64'd1 << ROOT_LIMIT_BIT)) begin
         d   = d >> 1;
         mag = mag >> 1;
      end
      t = (mag * 64'd65536 + d) / (64'd2 * d);
      if (t > 64'(HALF_Q16)) t = 64'(HALF_Q16);
      r.similarity = neg ? SAMPLE_W'(64'(HALF_Q16) - t) : SAMPLE_W'(64'(HALF_Q16) + t);
      return r;
   endfunction

   task automatic clear_run();
      run_length     = 0;
      acc_a          = 0;
      acc_b          = 0;
      acc_sq_a       = 0;
      acc_sq_b       = 0;
      acc_cross      = 0;
      run_overflowed = 0;
   endtask

   always @(posedge clock) begin
      logic [63:0] a, b;
      rsp_type     want;
      if (reset) begin
         clear_run();
         expected_rsps.delete();
      end else begin
         if (req_valid && req_ready) begin
            a = clamp_q16(req_data.sample_a);
            b = clamp_q16(req_data.sample_b);
            if (run_length >= MAX_SAMPLES) begin
               run_overflowed = 1;
            end else begin
               run_length++;
               acc_a     += a;
               acc_b     += b;
               acc_sq_a  += a * a;
               acc_sq_b  += b * b;
               acc_cross += a * b;
            end
            if (req_data.last_pair) begin
               expected_rsps.push_back(correlation_result());
               clear_run();
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report($sformatf("unexpected result item %p", rsp_data));
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.similarity !== want.similarity)
                  report($sformatf("similarity %0d, want %0d", rsp_data.similarity,
                                   want.similarity));
               if (rsp_data.flat_input !== want.flat_input)
                  report($sformatf("flat_input %b, want %b", rsp_data.flat_input,
                                   want.flat_input));
               if (rsp_data.overflow !== want.overflow)
                  report($sformatf("overflow %b, want %b", rsp_data.overflow, want.overflow));
            end
         end
      end
      results_owed = expected_rsps.size();
   end

endmodule

/* tb/sv/testbench.sv */
// pearson correlation similarity: top of the testbench
// drives paired sample vectors with random idling and random result stalls, gives the verdict
// depends on pcs_pkg, pcs_checker, pearson_correlation_similarity
`timescale 1ns / 1ps

module testbench;
   import pcs_pkg::*;

   localparam int unsigned MAX_SAMPLES = 4096;
   localparam int          CYCLE_LIMIT = 3000000;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;
   int      fail_count;
   int      results_owed;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      cycles = 0;

   always #6 clock = ~clock;

   pearson_correlation_similarity #(.MAX_SAMPLES(MAX_SAMPLES)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   pcs_checker #(.MAX_SAMPLES(MAX_SAMPLES)) i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .results_owed(results_owed)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_pair(input int a, input int b, input bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{sample_a: SAMPLE_W'(a), sample_b: SAMPLE_W'(b), last_pair: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic pick_samples(input int mode, output int a, output int b);
      a = $urandom_range(0, 65536);
      case (mode)
         0: begin
            a = $urandom_range(0, 131071);
            b = $urandom_range(0, 131071);
         end
         1: b = $urandom_range(0, 65536);
         2: b = (a + $urandom_range(0, 2000) > 65536) ? 65536 : a + $urandom_range(0, 2000);
         3: b = 65536 - a;
         default: b = 65536;
      endcase
   endtask

   task automatic send_vector(input int len, input int mode);
      int a, b;
      for (int i = 0; i < len; i++) begin
         pick_samples(mode, a, b);
         send_pair(a, b, i == len - 1);
      end
   endtask

   task automatic run_random(input int pairs);
      int sent, len;
      sent = 0;
      while (sent < pairs) begin
         case ($urandom_range(9))
            0: len = 1;
            1: len = $urandom_range(11, 40);
            default: len = $urandom_range(2, 10);
         endcase
         send_vector(len, $urandom_range(0, 4));
         sent += len;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single pair and constant runs are flat
      send_pair(0, 0, 1);
      send_pair(65536, 65536, 1);
      send_pair(1, 1, 0); send_pair(1, 2, 0); send_pair(1, 3, 1);
      send_pair(7, 500, 0); send_pair(9000, 500, 1);
      // perfect correlation and anticorrelation
      send_pair(0, 0, 0); send_pair(65536, 65536, 1);
      send_pair(65536, 0, 0); send_pair(0, 65536, 1);
      // above range saturates, then an in-range vector
      send_pair(131071, 5, 0); send_pair(0, 131071, 0); send_pair(100000, 70000, 1);
      send_pair(12345, 54321, 0); send_pair(43210, 1111, 0); send_pair(30000, 30001, 1);

      send_idle_pct = 0;  recv_stall_pct = 0;  run_random(200);
      send_idle_pct = 53; recv_stall_pct = 0;  run_random(200);
      send_idle_pct = 0;  recv_stall_pct = 53; run_random(200);
      send_idle_pct = 11; recv_stall_pct = 11; run_random(200);
      req_valid <= 1'b0;

      while (results_owed != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* files.f */
src/pcs_pkg.sv
src/pcs_mul.sv
src/pearson_correlation_similarity.sv
src/pcs_checker.sv
tb/sv/pcs_checker.sv
tb/sv/testbench.sv
